### rtl/sfpd_pkg.sv
package sfpd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CAP_DEPTH = 8;
    localparam int unsigned CAP_IDX_W = $clog2(CAP_DEPTH);
    localparam int unsigned CNT_W     = CAP_IDX_W + 1;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND = 2'd2;

    // Register values after reset
    localparam logic [BYTE_W-1:0] SYNC_RST    = 8'h55;
    localparam logic [BYTE_W-1:0] END_RST     = 8'hAA;
    localparam logic [BYTE_W-1:0] COMMAND_RST = 8'h00;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_value;
        logic [BYTE_W-1:0] end_value;
        logic [BYTE_W-1:0] command_value;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] ch1_byte0;
        logic [BYTE_W-1:0] ch1_byte1;
        logic [BYTE_W-1:0] ch1_byte2;
        logic [BYTE_W-1:0] ch1_byte3;
        logic [BYTE_W-1:0] ch2_byte0;
        logic [BYTE_W-1:0] ch2_byte1;
        logic [BYTE_W-1:0] ch2_byte2;
        logic [BYTE_W-1:0] ch2_byte3;
        logic              short_payload;
    } t_result;

    // Parser status toward the result stage
    typedef struct packed {
        logic frame_done;  // accepted byte closes a valid frame
        logic at_last_end; // next byte may close a frame
    } t_parse_status;

endpackage

### rtl/sfpd_if.sv
interface sfpd_byte_if import sfpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfpd_result_if import sfpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] ch1_byte0;
    logic [BYTE_W-1:0] ch1_byte1;
    logic [BYTE_W-1:0] ch1_byte2;
    logic [BYTE_W-1:0] ch1_byte3;
    logic [BYTE_W-1:0] ch2_byte0;
    logic [BYTE_W-1:0] ch2_byte1;
    logic [BYTE_W-1:0] ch2_byte2;
    logic [BYTE_W-1:0] ch2_byte3;
    logic              short_payload;

    modport source (
        output valid, input ready,
        output ch1_byte0, output ch1_byte1, output ch1_byte2, output ch1_byte3,
        output ch2_byte0, output ch2_byte1, output ch2_byte2, output ch2_byte3,
        output short_payload
    );
    modport sink (
        input valid, output ready,
        input ch1_byte0, input ch1_byte1, input ch1_byte2, input ch1_byte3,
        input ch2_byte0, input ch2_byte1, input ch2_byte2, input ch2_byte3,
        input short_payload
    );
endinterface

interface sfpd_cfg_if import sfpd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/sfpd_cfg_regs.sv
module sfpd_cfg_regs import sfpd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [CFG_IDX_W-1:0] i_wr_index,
    input  logic [BYTE_W-1:0]    i_wr_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the register index; unknown indexes drop the request
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_SYNC:    n_cfg.sync_value    = i_wr_data;
                CFG_END:     n_cfg.end_value     = i_wr_data;
                CFG_COMMAND: n_cfg.command_value = i_wr_data;
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_value    <= SYNC_RST;
            r_cfg.end_value     <= END_RST;
            r_cfg.command_value <= COMMAND_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/sfpd_parser.sv
module sfpd_parser import sfpd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_byte_en,
    input  logic [BYTE_W-1:0] i_byte,
    output t_parse_status     o_status,
    output t_result           o_result
);

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_SYNC2 = 4'd1;
    localparam logic [3:0] PH_SYNC3 = 4'd2;
    localparam logic [3:0] PH_CMD   = 4'd3;
    localparam logic [3:0] PH_LEN   = 4'd4;
    localparam logic [3:0] PH_DATA  = 4'd5;
    localparam logic [3:0] PH_END1  = 4'd6;
    localparam logic [3:0] PH_END2  = 4'd7;
    localparam logic [3:0] PH_END3  = 4'd8;

    logic [3:0]        r_phase;
    logic [3:0]        n_phase;
    logic [BYTE_W-1:0] r_left;
    logic [BYTE_W-1:0] n_left;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [BYTE_W-1:0] r_cap [CAP_DEPTH];
    logic              frame_start;
    logic              cap_wr;
    logic              done;

    logic sync_hit;
    logic end_hit;
    logic cmd_hit;

    assign sync_hit = (i_byte == i_cfg.sync_value);
    assign end_hit  = (i_byte == i_cfg.end_value);
    assign cmd_hit  = (i_byte == i_cfg.command_value);

    // Next phase; any mismatch drops back to idle and consumes the byte
    always_comb begin
        n_phase     = r_phase;
        n_left      = r_left;
        n_count     = r_count;
        frame_start = 1'b0;
        cap_wr      = 1'b0;
        done        = 1'b0;
        if (i_byte_en) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (sync_hit) begin
                        frame_start = 1'b1;
                        n_count     = '0;
                        n_left      = '0;
                        n_phase     = PH_SYNC2;
                    end
                end
                PH_SYNC2: n_phase = sync_hit ? PH_SYNC3 : PH_IDLE;
                PH_SYNC3: n_phase = sync_hit ? PH_CMD : PH_IDLE;
                PH_CMD:   n_phase = cmd_hit ? PH_LEN : PH_IDLE;
                PH_LEN: begin
                    n_left  = i_byte;
                    n_phase = PH_DATA;
                end
                PH_DATA: begin
                    // Store the first eight payload bytes, skip the rest
                    if (!r_count[CNT_W-1]) begin
                        cap_wr  = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                    if (r_left <= BYTE_W'(1)) begin
                        n_left  = '0;
                        n_phase = PH_END1;
                    end else begin
                        n_left = r_left - BYTE_W'(1);
                    end
                end
                PH_END1: n_phase = end_hit ? PH_END2 : PH_IDLE;
                PH_END2: n_phase = end_hit ? PH_END3 : PH_IDLE;
                PH_END3: begin
                    n_phase = PH_IDLE;
                    done    = end_hit;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_left  <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_count <= n_count;
        end
    end

    // Capture buffer: cleared at frame start, first eight payload bytes written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || frame_start) begin
            for (int k = 0; k < CAP_DEPTH; k++) begin
                r_cap[k] <= '0;
            end
        end else if (cap_wr) begin
            r_cap[r_count[CAP_IDX_W-1:0]] <= i_byte;
        end
    end

    assign o_status.frame_done  = done;
    assign o_status.at_last_end = (r_phase == PH_END3);

    assign o_result.ch1_byte0     = r_cap[0];
    assign o_result.ch1_byte1     = r_cap[1];
    assign o_result.ch1_byte2     = r_cap[2];
    assign o_result.ch1_byte3     = r_cap[3];
    assign o_result.ch2_byte0     = r_cap[4];
    assign o_result.ch2_byte1     = r_cap[5];
    assign o_result.ch2_byte2     = r_cap[6];
    assign o_result.ch2_byte3     = r_cap[7];
    assign o_result.short_payload = !r_count[CNT_W-1];

endmodule

### rtl/sfpd_out_reg.sv
module sfpd_out_reg import sfpd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_blocked,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // Hold the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid   = r_valid;
    assign o_blocked = r_valid && !i_ready;
    assign o_result  = r_result;

endmodule

### rtl/sync_framed_packet_deframer.sv
// Channel   Dir  Handshake       Payload
// i_byte    in   valid / ready   rx_byte[7:0]
// i_cfg     in   valid / ready   index[1:0], data[7:0] (0 sync, 1 end, 2 command)
// o_result  out  valid / ready   ch1_byte0..3, ch2_byte0..3, short_payload
//
// One byte is taken per cycle when ready; a completed frame shows on o_result
// the cycle after its last end byte is taken, from a single result register.
// Reset (synchronous, i_rst_n low) returns the parser to idle, empties the
// result register and restores sync 0x55, end 0xAA, command 0x00.
// i_byte.ready drops only when the parser waits for the last end byte while
// an earlier result is still held on o_result. i_cfg.ready is always high.
module sync_framed_packet_deframer import sfpd_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sfpd_byte_if.sink      i_byte,
    sfpd_cfg_if.sink       i_cfg,
    sfpd_result_if.source  o_result
);

    t_cfg          cfg;
    t_parse_status status;
    t_result       cap_result;
    t_result       out_result;
    logic          byte_en;
    logic          out_valid;
    logic          out_blocked;

    // Accept configuration requests at any time
    assign i_cfg.ready = 1'b1;

    sfpd_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    // Stall input only when this byte could close a frame and output is full
    assign i_byte.ready = !(status.at_last_end && out_blocked);
    assign byte_en      = i_byte.valid && i_byte.ready;

    sfpd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_byte_en(byte_en),
        .i_byte   (i_byte.rx_byte),
        .o_status (status),
        .o_result (cap_result)
    );

    sfpd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (status.frame_done),
        .i_result (cap_result),
        .i_ready  (o_result.ready),
        .o_valid  (out_valid),
        .o_blocked(out_blocked),
        .o_result (out_result)
    );

    assign o_result.valid         = out_valid;
    assign o_result.ch1_byte0     = out_result.ch1_byte0;
    assign o_result.ch1_byte1     = out_result.ch1_byte1;
    assign o_result.ch1_byte2     = out_result.ch1_byte2;
    assign o_result.ch1_byte3     = out_result.ch1_byte3;
    assign o_result.ch2_byte0     = out_result.ch2_byte0;
    assign o_result.ch2_byte1     = out_result.ch2_byte1;
    assign o_result.ch2_byte2     = out_result.ch2_byte2;
    assign o_result.ch2_byte3     = out_result.ch2_byte3;
    assign o_result.short_payload = out_result.short_payload;

`ifndef SYNTHESIS
    // A finished frame never lands on a result still waiting downstream
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.frame_done |-> (!out_valid || o_result.ready))
        else $error("frame completed while result register was blocked");

    // A finished frame is offered on the next cycle
    a_done_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.frame_done |=> o_result.valid)
        else $error("completed frame not presented");

    // Input stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_byte.ready |-> (o_result.valid && !o_result.ready))
        else $error("input stalled without a blocked result");
`endif

endmodule
